// File: src/skv_pkg.sv
// Shared types and constants for the sorted key/value table.
// No dependencies; the other files, except skv_ram, refer to this package by scoped names.
package skv_pkg;

   localparam int KEY_W       = 32;
   localparam int VLO_W       = 64;
   localparam int VHI_W       = 32;
   localparam int VAL_W       = VHI_W + VLO_W;
   localparam int ENTRY_W     = KEY_W + VAL_W;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_INSERT   = 2'd1,
      CMD_FINALIZE = 2'd2,
      CMD_FIND     = 2'd3
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;
      logic res_clear;
      logic exec_clear;
      logic exec_insert;
      logic lin_start;
      logic bs_start;
      logic srt_start;
      logic set_sorted;
      logic lin_step;
      logic match_set;
      logic bs_rd;
      logic bs_step;
      logic srt_tmp;
      logic srt_rd;
      logic srt_cmp;
      logic srt_put;
      logic out_load;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    sorted;
      logic    count_zero;
      logic    count_gt1;
      logic    key_eq;
      logic    lin_last;
      logic    bs_open;
      logic    srt_gt;
      logic    srt_j1;
      logic    srt_more;
      logic    out_free;
   } ctl_sts_type;

endpackage

// File: src/skv_req_if.sv
// Request channel: valid/ready handshake carrying one table command.
// Uses skv_pkg field widths.
interface skv_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  cmd;
   logic [skv_pkg::KEY_W-1:0]   key;
   logic [skv_pkg::VLO_W-1:0]   value_low;
   logic [skv_pkg::VHI_W-1:0]   value_high;

   modport source (output valid, cmd, key, value_low, value_high, input ready);
   modport sink   (input valid, cmd, key, value_low, value_high, output ready);
endinterface

// File: src/skv_rsp_if.sv
// Response channel: valid/ready handshake carrying one command result.
// Uses skv_pkg field widths.
interface skv_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [skv_pkg::VLO_W-1:0]         result_low;
   logic [skv_pkg::VHI_W-1:0]         result_high;
   logic                              dropped;
   logic [skv_pkg::COUNT_OUT_W-1:0]   entry_count;
   logic                              table_empty;

   modport source (output valid, found, result_low, result_high, dropped, entry_count,
                   table_empty, input ready);
   modport sink   (input valid, found, result_low, result_high, dropped, entry_count,
                   table_empty, output ready);
endinterface

// File: src/sorted_key_value_table.sv
// Top level of the sorted key/value table: sequencer plus datapath.
// Depends on skv_pkg, skv_req_if, skv_rsp_if, skv_ctrl, skv_datapath, skv_ram.
//
//   channel    dir   payload
//   req_chan   in    cmd, key, value_low, value_high
//   rsp_chan   out   found, result_low, result_high, dropped, entry_count, table_empty
//
// One command at a time. Clear and insert go from the execute state straight to done.
// Find: a linear scan while unsorted, a binary search once sorted.
// Finalize: insertion sort over the simple dual-port table RAM.
// Synchronous reset empties the table at once; no clearing pass.
// A stalled result is held in the output register; the next transfer is taken
// as soon as the sequencer is idle.
module sorted_key_value_table #(
   parameter int TABLE_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   skv_req_if.sink    req_chan,
   skv_rsp_if.source  rsp_chan
);

   skv_pkg::ctl_cmd_type ctl;
   skv_pkg::ctl_sts_type sts;
   logic                 req_ready;

   assign req_chan.ready = req_ready;

   skv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   skv_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_chan.cmd),
      .req_key         (req_chan.key),
      .req_value_low   (req_chan.value_low),
      .req_value_high  (req_chan.value_high),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_found       (rsp_chan.found),
      .rsp_result_low  (rsp_chan.result_low),
      .rsp_result_high (rsp_chan.result_high),
      .rsp_dropped     (rsp_chan.dropped),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_table_empty (rsp_chan.table_empty)
   );

endmodule

// File: src/skv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skv_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/skv_ctrl.sv
// Command sequencer: dispatches clear/insert/finalize/find, runs the
// linear scan, binary search and insertion sort loops. Uses skv_pkg.
module skv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  skv_pkg::ctl_sts_type  sts,
   output skv_pkg::ctl_cmd_type  ctl
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LIN_RD,
      ST_LIN_CHK,
      ST_BS_RD,
      ST_BS_CHK,
      ST_SRT_NEXT,
      ST_SRT_TMP,
      ST_SRT_RD,
      ST_SRT_CMP,
      ST_SRT_PUT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.res_clear = 1'b1;
            case (sts.cmd)
               skv_pkg::CMD_CLEAR: begin
                  ctl.exec_clear = 1'b1;
                  state_in       = ST_DONE;
               end
               skv_pkg::CMD_INSERT: begin
                  ctl.exec_insert = 1'b1;
                  state_in        = ST_DONE;
               end
               skv_pkg::CMD_FINALIZE: begin
                  if (sts.sorted) begin
                     state_in = ST_DONE;
                  end else if (sts.count_gt1) begin
                     ctl.srt_start = 1'b1;
                     state_in      = ST_SRT_NEXT;
                  end else begin
                     ctl.set_sorted = 1'b1;
                     state_in       = ST_DONE;
                  end
               end
               skv_pkg::CMD_FIND: begin
                  if (sts.sorted) begin
                     ctl.bs_start = 1'b1;
                     state_in     = ST_BS_RD;
                  end else if (sts.count_zero) begin
                     state_in = ST_DONE;
                  end else begin
                     ctl.lin_start = 1'b1;
                     state_in      = ST_LIN_RD;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_LIN_RD: begin
            state_in = ST_LIN_CHK;
         end
         ST_LIN_CHK: begin
            if (sts.key_eq) begin
               ctl.match_set = 1'b1;
               state_in      = ST_DONE;
            end else if (sts.lin_last) begin
               state_in = ST_DONE;
            end else begin
               ctl.lin_step = 1'b1;
               state_in     = ST_LIN_RD;
            end
         end
         ST_BS_RD: begin
            if (sts.bs_open) begin
               ctl.bs_rd = 1'b1;
               state_in  = ST_BS_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BS_CHK: begin
            if (sts.key_eq) begin
               ctl.match_set = 1'b1;
               state_in      = ST_DONE;
            end else begin
               ctl.bs_step = 1'b1;
               state_in    = ST_BS_RD;
            end
         end
         ST_SRT_NEXT: begin
            if (sts.srt_more) begin
               state_in = ST_SRT_TMP;
            end else begin
               ctl.set_sorted = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_SRT_TMP: begin
            ctl.srt_tmp = 1'b1;
            state_in    = ST_SRT_RD;
         end
         ST_SRT_RD: begin
            ctl.srt_rd = 1'b1;
            state_in   = ST_SRT_CMP;
         end
         ST_SRT_CMP: begin
            ctl.srt_cmp = 1'b1;
            if (!sts.srt_gt) begin
               state_in = ST_SRT_NEXT;
            end else if (sts.srt_j1) begin
               state_in = ST_SRT_PUT;
            end else begin
               state_in = ST_SRT_RD;
            end
         end
         ST_SRT_PUT: begin
            ctl.srt_put = 1'b1;
            state_in    = ST_SRT_NEXT;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/skv_datapath.sv
// Table storage, count/sorted state, scan and sort indexes, result register.
// Uses skv_pkg and skv_ram.
module skv_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [1:0]                           req_cmd,
   input  logic [skv_pkg::KEY_W-1:0]            req_key,
   input  logic [skv_pkg::VLO_W-1:0]            req_value_low,
   input  logic [skv_pkg::VHI_W-1:0]            req_value_high,
   input  skv_pkg::ctl_cmd_type                 ctl,
   output skv_pkg::ctl_sts_type                 sts,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [skv_pkg::VLO_W-1:0]            rsp_result_low,
   output logic [skv_pkg::VHI_W-1:0]            rsp_result_high,
   output logic                                 rsp_dropped,
   output logic [skv_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic                                 rsp_table_empty
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   skv_pkg::cmd_type                cmd_ff;
   logic [skv_pkg::KEY_W-1:0]       key_ff;
   logic [skv_pkg::VLO_W-1:0]       vlo_ff;
   logic [skv_pkg::VHI_W-1:0]       vhi_ff;
   logic [CW-1:0]                   count_ff;
   logic                            sorted_ff;
   logic [CW-1:0]                   i_ff, j_ff, lo_ff, he_ff;
   logic [AW-1:0]                   mid_ff;
   logic [skv_pkg::ENTRY_W-1:0]     tmp_ff;
   logic                            res_found_ff, res_drop_ff;
   logic [skv_pkg::VAL_W-1:0]       res_val_ff;
   logic                            out_valid_ff, out_found_ff, out_drop_ff, out_empty_ff;
   logic [skv_pkg::VAL_W-1:0]       out_val_ff;
   logic [skv_pkg::COUNT_OUT_W-1:0] out_count_ff;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr, rd_addr;
   logic [skv_pkg::ENTRY_W-1:0]     wr_data, rd_data;
   logic [skv_pkg::KEY_W-1:0]       rd_key, tmp_key;
   logic [CW-1:0]                   span, mid_w, jm1, mid_ext;
   logic                            full, srt_gt;
   logic [CW+skv_pkg::COUNT_OUT_W-1:0] cnt_wide;

   assign rd_key  = rd_data[skv_pkg::ENTRY_W-1 -: skv_pkg::KEY_W];
   assign tmp_key = tmp_ff[skv_pkg::ENTRY_W-1 -: skv_pkg::KEY_W];
   assign span    = he_ff - lo_ff - ONE_C;
   assign mid_w   = lo_ff + (span >> 1);
   assign mid_ext = CW'(mid_ff);
   assign jm1     = j_ff - ONE_C;
   assign full    = (count_ff == DEPTH_C);
   assign srt_gt  = (rd_key > tmp_key);
   assign cnt_wide = {{skv_pkg::COUNT_OUT_W{1'b0}}, count_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = j_ff[AW-1:0];
      wr_data = tmp_ff;
      if (ctl.exec_insert && !full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = {key_ff, vhi_ff, vlo_ff};
      end else if (ctl.srt_cmp) begin
         wr_en   = 1'b1;
         wr_data = srt_gt ? rd_data : tmp_ff;
      end else if (ctl.srt_put) begin
         wr_en   = 1'b1;
      end
   end

   always_comb begin
      rd_addr = i_ff[AW-1:0];
      if (ctl.bs_rd) begin
         rd_addr = mid_w[AW-1:0];
      end else if (ctl.srt_rd) begin
         rd_addr = jm1[AW-1:0];
      end
   end

   skv_ram #(
      .WIDTH (skv_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request capture, loop indexes, result and output registers
   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         cmd_ff <= skv_pkg::cmd_type'(req_cmd);
         key_ff <= req_key;
         vlo_ff <= req_value_low;
         vhi_ff <= req_value_high;
      end
      if (ctl.lin_start) begin
         i_ff <= '0;
      end else if (ctl.srt_start) begin
         i_ff <= ONE_C;
      end else if (ctl.lin_step || ctl.srt_put || (ctl.srt_cmp && !srt_gt)) begin
         i_ff <= i_ff + ONE_C;
      end
      if (ctl.srt_tmp) begin
         j_ff   <= i_ff;
         tmp_ff <= rd_data;
      end else if (ctl.srt_cmp && srt_gt) begin
         j_ff <= jm1;
      end
      if (ctl.bs_start) begin
         lo_ff <= '0;
         he_ff <= count_ff;
      end else if (ctl.bs_step) begin
         if (rd_key < key_ff) begin
            lo_ff <= mid_ext + ONE_C;
         end else begin
            he_ff <= mid_ext;
         end
      end
      if (ctl.bs_rd) begin
         mid_ff <= mid_w[AW-1:0];
      end
      if (ctl.res_clear) begin
         res_found_ff <= 1'b0;
         res_drop_ff  <= ctl.exec_insert && full;
         res_val_ff   <= '0;
      end else if (ctl.match_set) begin
         res_found_ff <= 1'b1;
         res_val_ff   <= rd_data[skv_pkg::VAL_W-1:0];
      end
      if (ctl.out_load) begin
         out_found_ff <= res_found_ff;
         out_val_ff   <= res_val_ff;
         out_drop_ff  <= res_drop_ff;
         out_count_ff <= cnt_wide[skv_pkg::COUNT_OUT_W-1:0];
         out_empty_ff <= (count_ff == '0);
      end
   end

   // table control state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sorted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctl.exec_clear) begin
            count_ff  <= '0;
            sorted_ff <= 1'b0;
         end else if (ctl.exec_insert && !full) begin
            count_ff  <= count_ff + ONE_C;
            sorted_ff <= 1'b0;
         end else if (ctl.set_sorted) begin
            sorted_ff <= 1'b1;
         end
         if (ctl.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.cmd        = cmd_ff;
      sts.sorted     = sorted_ff;
      sts.count_zero = (count_ff == '0);
      sts.count_gt1  = (count_ff > ONE_C);
      sts.key_eq     = (rd_key == key_ff);
      sts.lin_last   = ((i_ff + ONE_C) == count_ff);
      sts.bs_open    = (lo_ff < he_ff);
      sts.srt_gt     = srt_gt;
      sts.srt_j1     = (j_ff == ONE_C);
      sts.srt_more   = (i_ff < count_ff);
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_result_low  = out_val_ff[skv_pkg::VLO_W-1:0];
   assign rsp_result_high = out_val_ff[skv_pkg::VAL_W-1 -: skv_pkg::VHI_W];
   assign rsp_dropped     = out_drop_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_table_empty = out_empty_ff;

endmodule
